@@ rtl/core/asmi_pkg.sv @@
package asmi_pkg;

  localparam int ASMI_MAX_ITEMS = 64;
  localparam int SCORE_W        = 32;
  localparam int SIDX_W         = 6;
  localparam int OC_W           = 7;
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 32;

  localparam logic [OC_W-1:0] OC_RESET = 7'd64;

  // Register index of order_count in the configuration space.
  localparam logic REG_ORDER_COUNT = 1'b0;

  // Control for the shared minimum-selection unit.
  typedef struct packed {
    logic clr;
    logic smp;
    logic taken;
  } minsel_ctl_t;

  // Flipping the sign bit turns a two's complement score into an unsigned key
  // that sorts in the same order.
  function automatic logic [SCORE_W-1:0] order_key(input logic [SCORE_W-1:0] v);
    order_key = v ^ {1'b1, {(SCORE_W-1){1'b0}}};
  endfunction

endpackage

@@ rtl/core/asmi_chan_if.sv @@
interface asmi_in_if;
  import asmi_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic                      is_last;

  modport source (output valid, output score, output is_last, input ready);
  modport sink   (input valid, input score, input is_last, output ready);
endinterface

interface asmi_out_if;
  import asmi_pkg::*;

  logic              valid;
  logic              ready;
  logic [SIDX_W-1:0] sorted_index;
  logic              last_out;

  modport source (output valid, output sorted_index, output last_out, input ready);
  modport sink   (input valid, input sorted_index, input last_out, output ready);
endinterface

@@ rtl/core/asmi_ram.sv @@
module asmi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/asmi_minsel.sv @@
module asmi_minsel #(
  parameter int IW = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  asmi_pkg::minsel_ctl_t           ctl,
  input  logic [asmi_pkg::SCORE_W-1:0]    data,
  input  logic [IW-1:0]                   pos,
  output logic [IW-1:0]                   best_pos,
  output logic                            found
);
  import asmi_pkg::*;

  logic               found_r, found_nxt;
  logic [SCORE_W-1:0] best_key_r, best_key_nxt;
  logic [IW-1:0]      best_pos_r, best_pos_nxt;
  logic [SCORE_W-1:0] key;
  logic               better;

  assign key = order_key(data);
  // Strict less-than keeps the lower position among equal scores.
  assign better = ctl.smp && !ctl.taken && (!found_r || (key < best_key_r));

  always_comb begin
    found_nxt    = found_r;
    best_key_nxt = best_key_r;
    best_pos_nxt = best_pos_r;
    if (ctl.clr) begin
      found_nxt = 1'b0;
    end else if (better) begin
      found_nxt    = 1'b1;
      best_key_nxt = key;
      best_pos_nxt = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    best_key_r <= best_key_nxt;
    best_pos_r <= best_pos_nxt;
  end

  assign best_pos = best_pos_r;
  assign found    = found_r;

  a_clr_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |=> !found_r)
    else $error("selection unit not emptied after clear");

  a_taken_kept_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.smp && ctl.taken && !ctl.clr) |=> (found_r == $past(found_r)))
    else $error("taken entry entered the selection");

  a_key_non_increasing: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && !ctl.clr) |=> (found_r && best_key_r <= $past(best_key_r)))
    else $error("selected key grew during a scan");

endmodule

@@ rtl/core/argsort_selection_min_index.sv @@
// An item without is_last is stored if the store has room; the block stays ready.
// The item with is_last starts emission: for each position the n stored values are
// read once each through the value memory's single read port, the read data is
// registered, and the result is handed over once the output register is free.
// Reset clears the fill count, taken flags, sequencer and output register; the value
// memory is not cleared, as only entries already written in the current set are read.
module argsort_selection_min_index #(
  parameter int MAX_ITEMS = asmi_pkg::ASMI_MAX_ITEMS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  asmi_in_if.sink                     in_ch,
  asmi_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [asmi_pkg::CFG_AW-1:0] paddr,
  input  logic [asmi_pkg::CFG_DW-1:0] pwdata,
  output logic [asmi_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import asmi_pkg::*;

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [OC_W-1:0]   order_count_r, order_count_nxt;
  logic [CW-1:0]     load_cnt_r, load_cnt_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     e_r, e_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]     pos_d_r, pos_d_nxt;
  logic [MAX_ITEMS-1:0] taken_r, taken_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [SIDX_W-1:0] out_idx_r, out_idx_nxt;
  logic              out_last_r, out_last_nxt;

  logic               in_acc;
  logic               store_full;
  logic [CW-1:0]      n_new;
  logic [OC_W-1:0]    k0;
  logic               cfg_wr;
  logic               out_free;
  logic               emit_last;
  minsel_ctl_t        ms_ctl;
  logic [SCORE_W-1:0] rd_data;
  logic [IW-1:0]      best_pos;
  logic               found;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign order_count_nxt = (cfg_wr && paddr[2] == REG_ORDER_COUNT) ? pwdata[OC_W-1:0]
                                                                    : order_count_r;
  assign prdata = (paddr[2] == REG_ORDER_COUNT) ? {{(CFG_DW-OC_W){1'b0}}, order_count_r}
                                                : '0;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign store_full  = (load_cnt_r == MAX_CNT);
  assign n_new       = store_full ? load_cnt_r : load_cnt_r + 1'b1;
  assign k0          = (order_count_r == '0) ? OC_W'(1) : order_count_r;

  assign out_free  = !out_vld_r || out_ch.ready;
  assign emit_last = (CW'(e_r + 1'b1) == k_r);

  asmi_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (in_acc && !store_full),
    .waddr (load_cnt_r[IW-1:0]),
    .wdata (in_ch.score),
    .raddr (j_r[IW-1:0]),
    .rdata (rd_data)
  );

  assign ms_ctl.smp   = rd_vld_r;
  assign ms_ctl.taken = taken_r[pos_d_r];
  assign ms_ctl.clr   = (state_r == ST_IDLE) || (state_r == ST_EMIT && out_free);

  asmi_minsel #(
    .IW (IW)
  ) u_minsel (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ms_ctl),
    .data     (rd_data),
    .pos      (pos_d_r),
    .best_pos (best_pos),
    .found    (found)
  );

  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    k_nxt        = k_r;
    e_nxt        = e_r;
    j_nxt        = j_r;
    rd_vld_nxt   = 1'b0;
    pos_d_nxt    = j_r[IW-1:0];
    taken_nxt    = taken_r;
    out_idx_nxt  = out_idx_r;
    out_last_nxt = out_last_r;
    out_vld_nxt  = out_ch.ready ? 1'b0 : out_vld_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          load_cnt_nxt = n_new;
          if (in_ch.is_last) begin
            k_nxt     = (k0 > OC_W'(n_new)) ? n_new : k0[CW-1:0];
            e_nxt     = '0;
            j_nxt     = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = 1'b1;
        if (CW'(j_r + 1'b1) == load_cnt_r) begin
          state_nxt = ST_FLUSH;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_idx_nxt  = SIDX_W'(best_pos);
          out_last_nxt = emit_last;
          taken_nxt[best_pos] = 1'b1;
          e_nxt        = e_r + 1'b1;
          j_nxt        = '0;
          if (emit_last) begin
            // Set complete: the store is emptied for the next one.
            taken_nxt    = '0;
            load_cnt_nxt = '0;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      order_count_r <= OC_RESET;
      load_cnt_r    <= '0;
      rd_vld_r      <= 1'b0;
      taken_r       <= '0;
      out_vld_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      order_count_r <= order_count_nxt;
      load_cnt_r    <= load_cnt_nxt;
      rd_vld_r      <= rd_vld_nxt;
      taken_r       <= taken_nxt;
      out_vld_r     <= out_vld_nxt;
    end
    k_r        <= k_nxt;
    e_r        <= e_nxt;
    j_r        <= j_nxt;
    pos_d_r    <= pos_d_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.sorted_index = out_idx_r;
  assign out_ch.last_out     = out_last_r;

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= MAX_CNT)
    else $error("fill count beyond store depth");

  a_count_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (k_r >= CW'(1) && k_r <= load_cnt_r && e_r < k_r))
    else $error("emission count out of range");

  a_result_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (found && !taken_r[best_pos]))
    else $error("no untaken entry selected at emission");

  a_set_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free && emit_last) |=>
      (state_r == ST_IDLE && load_cnt_r == '0 && taken_r == '0 && out_last_r))
    else $error("set not closed after final result");

endmodule

@@ verif/tb_argsort_selection_min_index.sv @@
`timescale 1ns / 1ps

module tb_argsort_selection_min_index;
  import asmi_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 4 * (ASMI_MAX_ITEMS + 2);
  localparam int LONG_HOLD      = 500;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 32;
  localparam int DIRECTED_ROWS  = 20;

  localparam logic [CFG_AW-1:0] ORDER_COUNT_ADDR = CFG_AW'(4 * REG_ORDER_COUNT);
  // First address past the register file; writes there must be ignored.
  localparam logic [CFG_AW-1:0] SPARE_ADDR = CFG_AW'(4 * (REG_ORDER_COUNT + 1));

  localparam logic [SCORE_W-1:0] SCORE_MIN  = 32'h8000_0000;
  localparam logic [SCORE_W-1:0] SCORE_MAX  = 32'h7FFF_FFFF;
  localparam logic [SCORE_W-1:0] SCORE_ONE  = 32'h0001_0000;
  localparam logic [SCORE_W-1:0] SCORE_MONE = 32'hFFFF_0000;

  typedef struct packed {
    logic [SIDX_W-1:0] idx;
    logic              last;
  } position_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               last;
    logic               typed;
    logic [SIDX_W-1:0]  want_idx;
    logic               want_last;
  } stim_row_t;

  // Typed rows are single-score sets, whose only result is position 0.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{32'h0000_0000, 1'b1, 1'b1, 6'd0, 1'b1},
    '{SCORE_MAX,     1'b1, 1'b1, 6'd0, 1'b1},
    '{SCORE_MIN,     1'b1, 1'b1, 6'd0, 1'b1},
    '{SCORE_MAX,     1'b0, 1'b0, 6'd0, 1'b0},
    '{SCORE_MIN,     1'b1, 1'b0, 6'd0, 1'b0},
    '{32'h0005_0000, 1'b0, 1'b0, 6'd0, 1'b0},
    '{32'h0005_0000, 1'b0, 1'b0, 6'd0, 1'b0},
    '{32'h0005_0000, 1'b1, 1'b0, 6'd0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 6'd0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, 6'd0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 6'd0, 1'b0},
    '{SCORE_MIN,     1'b0, 1'b0, 6'd0, 1'b0},
    '{SCORE_MAX,     1'b0, 1'b0, 6'd0, 1'b0},
    '{SCORE_ONE,     1'b1, 1'b0, 6'd0, 1'b0},
    '{SCORE_MONE,    1'b0, 1'b0, 6'd0, 1'b0},
    '{32'h0000_0003, 1'b0, 1'b0, 6'd0, 1'b0},
    '{SCORE_MONE,    1'b0, 1'b0, 6'd0, 1'b0},
    '{32'h0000_0003, 1'b1, 1'b0, 6'd0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 6'd0, 1'b0},
    '{32'h5555_5555, 1'b1, 1'b0, 6'd0, 1'b0}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  asmi_in_if  in_if ();
  asmi_out_if out_if ();

  argsort_selection_min_index dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #CLK_HALF clk = ~clk;

  // Predictor state: the scores of the set being loaded and the register copy.
  logic [SCORE_W-1:0] held_scores [ASMI_MAX_ITEMS];
  int                 held_n;
  logic [OC_W-1:0]    order_count_q;
  position_t          fresh_positions [$];
  position_t          expected_positions [$];

  int errors;
  int sent;
  int burst_left;
  bit gaps_on;
  int hold_request;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Stores one score and, on the closing score of a set, ranks the set by
  // repeated minimum search; the strict compare keeps the lower position on ties.
  function automatic void absorb_score(input logic [SCORE_W-1:0] s, input logic l);
    bit used [ASMI_MAX_ITEMS];
    int keep;
    int best;
    fresh_positions.delete();
    if (held_n < ASMI_MAX_ITEMS) begin
      held_scores[held_n] = s;
      held_n++;
    end
    if (!l) return;
    keep = (order_count_q == 0) ? 1 : int'(order_count_q);
    if (keep > held_n) keep = held_n;
    for (int i = 0; i < keep; i++) begin
      best = -1;
      for (int j = 0; j < held_n; j++) begin
        if (!used[j] && (best < 0 || $signed(held_scores[j]) < $signed(held_scores[best])))
          best = j;
      end
      used[best] = 1'b1;
      fresh_positions.push_back('{idx: SIDX_W'(best), last: (i == keep - 1)});
    end
    held_n = 0;
  endfunction

  // Offers one item and returns at the edge that accepts it, with valid left high.
  task automatic send_item(input logic [SCORE_W-1:0] s, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.score   <= s;
    in_if.is_last <= l;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
    sent++;
  endtask

  task automatic send_checked(input logic [SCORE_W-1:0] s, input logic l);
    send_item(s, l);
    absorb_score(s, l);
    foreach (fresh_positions[i]) expected_positions.push_back(fresh_positions[i]);
  endtask

  // Stops offering and waits until every expected position has been taken.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_order_count();
    logic [CFG_DW-1:0] rd;
    apb_access(1'b0, ORDER_COUNT_ADDR, '0, rd);
    if (rd !== {{(CFG_DW - OC_W){1'b0}}, order_count_q})
      report_mismatch("order_count readback", rd, 32'(order_count_q));
  endtask

  task automatic set_order_count(input logic [OC_W-1:0] value);
    logic [CFG_DW-1:0] rd;
    // Upper data bits are random and must be dropped by the register.
    apb_access(1'b1, ORDER_COUNT_ADDR, {(CFG_DW - OC_W)'($urandom()), value}, rd);
    order_count_q = value;
    check_order_count();
  endtask

  function automatic logic [SCORE_W-1:0] pick_score(input logic [SCORE_W-1:0] base);
    case ($urandom_range(0, 9))
      0, 1, 2: pick_score = $urandom();
      3, 4: begin
        case ($urandom_range(0, 5))
          0: pick_score = SCORE_MIN;
          1: pick_score = SCORE_MAX;
          2: pick_score = '0;
          3: pick_score = '1;
          4: pick_score = SCORE_ONE;
          default: pick_score = SCORE_MONE;
        endcase
      end
      // A narrow spread around a per-set base makes ties common.
      5, 6, 7: pick_score = base + $urandom_range(0, 3);
      default: pick_score = $urandom_range(0, 31) - 16;
    endcase
  endfunction

  // Receiver: changes its stall rate now and then, and honours a long hold-off.
  initial begin
    int mode_left;
    int stall_pct;
    int hold_left;
    mode_left = 0;
    stall_pct = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 70;
          default: stall_pct = 90;
        endcase
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    position_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_positions.size() == 0) begin
        report_mismatch("result with none expected", 32'(out_if.sorted_index), '0);
      end else begin
        want = expected_positions.pop_front();
        if (out_if.sorted_index !== want.idx)
          report_mismatch("sorted_index", 32'(out_if.sorted_index), 32'(want.idx));
        if (out_if.last_out !== want.last)
          report_mismatch("last_out", 32'(out_if.last_out), 32'(want.last));
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [SCORE_W-1:0] base;
    logic [CFG_DW-1:0]  rd;
    int                 len;
    int                 pick;
    int                 phase_stop;
    errors        = 0;
    sent          = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    hold_request  = 0;
    held_n        = 0;
    order_count_q = OC_RESET;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.score   <= '0;
    in_if.is_last <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_order_count();
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_item(directed_rows[r].score, directed_rows[r].last);
      absorb_score(directed_rows[r].score, directed_rows[r].last);
      if (directed_rows[r].typed)
        expected_positions.push_back('{idx: directed_rows[r].want_idx,
                                       last: directed_rows[r].want_last});
      else
        foreach (fresh_positions[i]) expected_positions.push_back(fresh_positions[i]);
    end
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_order_count(OC_W'(1));
        1: set_order_count(OC_W'(0));
        2: set_order_count(OC_W'(127));
        3: set_order_count(OC_W'(ASMI_MAX_ITEMS));
        4: set_order_count(OC_W'(2));
        5: set_order_count(OC_W'($urandom_range(1, ASMI_MAX_ITEMS)));
        6: begin
          set_order_count(OC_W'(3));
          apb_access(1'b1, SPARE_ADDR, $urandom(), rd);
          check_order_count();
        end
        default: set_order_count(OC_W'($urandom_range(ASMI_MAX_ITEMS + 1, 126)));
      endcase
      gaps_on = (phase % 3 != 2);
      // The receiver holds off while sets keep coming, so the block backs up
      // and must stall its input transactions.
      if (phase == 3) hold_request = LONG_HOLD;
      phase_stop = sent + PHASE_ITEMS;
      while (sent < phase_stop) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      len = $urandom_range(1, 8);
        else if (pick < 90) len = $urandom_range(9, 24);
        else if (pick < 98) len = $urandom_range(25, ASMI_MAX_ITEMS);
        else                len = $urandom_range(ASMI_MAX_ITEMS + 1, ASMI_MAX_ITEMS + 6);
        base = $urandom();
        for (int i = 0; i < len; i++) send_checked(pick_score(base), i == len - 1);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
